/* hw/rtl/mcsfh_pkg.sv */
// Shared types for the multi-client serial hub: item modes and sequencer states.
`default_nettype none

package mcsfh_pkg;

   typedef enum logic [2:0] {
      MODE_REGISTER = 3'd0,
      MODE_RX_BYTE  = 3'd1,
      MODE_READ     = 3'd2,
      MODE_TX_BYTE  = 3'd3,
      MODE_TX_START = 3'd4,
      MODE_TX_DONE  = 3'd5
   } mode_type;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_EXEC  = 7'b0000010,
      ST_RING  = 7'b0000100,
      ST_SCAN  = 7'b0001000,
      ST_FILL  = 7'b0010000,
      ST_TXRD  = 7'b0100000,
      ST_TXOUT = 7'b1000000
   } state_type;

endpackage

`default_nettype wire

/* hw/rtl/multi_client_serial_fifo_hub_unit.sv */
// Top level of the multi-client serial hub: sequencer, output register, assertions.
//
// Usage: one item per req_ beat (mode, client, data_byte, msg_length,
// byte_position); results leave on the rsp_ channel, rsp_last on the final
// beat of each item. Receive-byte and transmit-done items give no beat.
// Items are worked one at a time; req_stall is high while one is in work.
// Steps from accept until the next item can be taken (output free):
//   register, receive byte, transmit byte, done, unused modes: execute only
//   read: pointer table read, then ring read at that pointer
//   start: execute, then a scan of the busy-free case, one client per cycle
//   up to CLIENTS clients; when a client is found, its fill count read,
//   then a registered store read and an output step per line byte.
// The state sits in four synchronous RAMs: the receive ring, the transmit
// store, and per-client read pointer and fill count tables whose valid bits
// clear at reset, so no clearing pass is needed.
// rsp_ is a single output register: a new item is accepted while a result
// waits; when rsp_stall holds, the sequencer waits only where it must emit.
// reset is synchronous, active high: no clients, empty ring, empty buffers.
`default_nettype none

module multi_client_serial_fifo_hub_unit #(
   parameter int CLIENTS       = 16,
   parameter int RX_RING_DEPTH = 64,
   parameter int TX_CAPACITY   = 64
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [2:0] req_mode,
   input  wire logic [3:0] req_client,
   input  wire logic [7:0] req_data_byte,
   input  wire logic [7:0] req_msg_length,
   input  wire logic [7:0] req_byte_position,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic            rsp_ok,
   output logic      [3:0] rsp_client_id,
   output logic      [7:0] rsp_out_byte,
   output logic            rsp_ring_empty,
   output logic            rsp_line_valid,
   output logic            rsp_last
);

   import mcsfh_pkg::*;

   localparam int CLW  = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
   localparam int RAW  = $clog2(RX_RING_DEPTH);
   localparam int FW   = $clog2(TX_CAPACITY);
   localparam int CNTW = $clog2(CLIENTS + 1);
   localparam int TXD  = CLIENTS * TX_CAPACITY;
   localparam int TAW  = $clog2(TXD);

   localparam logic [8:0]      CAP9        = 9'(TX_CAPACITY);
   localparam logic [6:0]      CLIENTS7    = 7'(CLIENTS);
   localparam logic [CNTW-1:0] CLIENTS_CNT = CNTW'(CLIENTS);
   localparam logic [RAW-1:0]  RING_LAST   = RAW'(RX_RING_DEPTH - 1);
   localparam logic [CLW-1:0]  CLIENT_LAST = CLW'(CLIENTS - 1);

   // sequencer and bookkeeping
   state_type         state_ff, state_in;
   logic [CNTW-1:0]   count_ff, count_in;
   logic [RAW-1:0]    wp_ff, wp_in;
   logic [RAW-1:0]    rp_ff, rp_in;
   logic              busy_ff, busy_in;
   logic              acc_ff, acc_in;
   logic [CLIENTS-1:0] nonempty_ff, nonempty_in;
   logic [CLW-1:0]    scan_ff, scan_in;
   logic [FW-1:0]     k_ff, k_in;
   logic [FW-1:0]     n_ff, n_in;

   // latched item
   logic [2:0]        mode_ff;
   logic [3:0]        client_ff;
   logic [7:0]        data_ff;
   logic [7:0]        mlen_ff;
   logic [7:0]        pos_ff;

   // output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_ok_ff;
   logic [3:0]        rsp_id_ff;
   logic [7:0]        rsp_byte_ff;
   logic              rsp_empty_ff;
   logic              rsp_line_ff;
   logic              rsp_last_ff;

   logic              rsp_load;
   logic              ld_ok, ld_empty, ld_line, ld_last;
   logic [3:0]        ld_id;
   logic [7:0]        ld_byte;

   // memory ports
   logic              ring_we;
   logic [RAW-1:0]    ring_raddr;
   logic [7:0]        ring_rd;
   logic              rp_we;
   logic [RAW-1:0]    rp_wdata;
   logic [CLW-1:0]    rp_raddr;
   logic [RAW-1:0]    rp_rd;
   logic              fill_we;
   logic [CLW-1:0]    fill_waddr;
   logic [FW-1:0]     fill_wdata;
   logic [CLW-1:0]    fill_raddr;
   logic [FW-1:0]     fill_rd;
   logic              tx_we;
   logic [TAW-1:0]    tx_waddr;
   logic [TAW-1:0]    tx_raddr;
   logic [7:0]        tx_rd;

   // decoded item
   logic              accept;
   logic              out_free;
   logic [CLW-1:0]    req_idx;
   logic [CLW-1:0]    cl_idx;
   logic              in_range;
   logic              head;
   logic [8:0]        fsum;
   logic [8:0]        fone;
   logic              acc_new;
   logic              store;
   logic              tx_last;
   logic [RAW-1:0]    rp_next;
   logic              tx_phase;

   assign accept    = req_valid & (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign req_idx  = CLW'(req_client);
   assign cl_idx   = CLW'(client_ff);
   assign in_range = (7'(client_ff) < CLIENTS7);

   // message admission, decided at the head byte and kept for the rest
   assign head    = (pos_ff == 8'd0);
   assign fsum    = {1'b0, mlen_ff} + 9'(fill_rd);
   assign fone    = 9'(fill_rd) + 9'd1;
   assign acc_new = head ? (({1'b0, mlen_ff} <= CAP9) && (fsum < CAP9)) : acc_ff;
   assign store   = acc_new && (pos_ff < mlen_ff) && (fone < CAP9);

   assign tx_last = ((FW + 1)'(k_ff) + (FW + 1)'(1)) == {1'b0, n_ff};
   assign rp_next = (rp_ff == RING_LAST) ? '0 : rp_ff + 1'b1;

   assign tx_phase = state_ff inside {ST_SCAN, ST_FILL, ST_TXRD, ST_TXOUT};

   // table read addresses: the next item's client while idle, else the held one
   // (the scanned client while sending), so a waiting step re-reads the same entry
   assign rp_raddr   = (state_ff == ST_IDLE) ? req_idx : cl_idx;
   assign fill_raddr = (state_ff == ST_IDLE) ? req_idx : (tx_phase ? scan_ff : cl_idx);
   assign ring_raddr = (state_ff == ST_EXEC) ? rp_rd : rp_ff;
   assign tx_waddr   = TAW'(int'(cl_idx) * TX_CAPACITY + int'(fill_rd));
   assign tx_raddr   = TAW'(int'(scan_ff) * TX_CAPACITY + int'(k_ff));
   assign rp_wdata   = rp_next;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      busy_in     = busy_ff;
      acc_in      = acc_ff;
      nonempty_in = nonempty_ff;
      scan_in     = scan_ff;
      k_in        = k_ff;
      n_in        = n_ff;
      rsp_load    = 1'b0;
      ld_ok       = 1'b0;
      ld_id       = 4'd0;
      ld_byte     = 8'd0;
      ld_empty    = 1'b0;
      ld_line     = 1'b0;
      ld_last     = 1'b1;
      ring_we     = 1'b0;
      rp_we       = 1'b0;
      fill_we     = 1'b0;
      fill_waddr  = cl_idx;
      fill_wdata  = FW'(fone);
      tx_we       = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            case (mode_type'(mode_ff))
               MODE_REGISTER: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     if (count_ff < CLIENTS_CNT) begin
                        ld_ok    = 1'b1;
                        ld_id    = 4'(count_ff);
                        count_in = count_ff + 1'b1;
                     end
                     state_in = ST_IDLE;
                  end
               end

               MODE_RX_BYTE: begin
                  ring_we  = 1'b1;
                  wp_in    = (wp_ff == RING_LAST) ? '0 : wp_ff + 1'b1;
                  state_in = ST_IDLE;
               end

               MODE_READ: begin
                  ld_id = client_ff;
                  if (!in_range) begin
                     if (out_free) begin
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else if (rp_rd == wp_ff) begin
                     // nothing to read: pointer stays
                     if (out_free) begin
                        rsp_load = 1'b1;
                        ld_empty = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     rp_in    = rp_rd;
                     state_in = ST_RING;
                  end
               end

               MODE_TX_BYTE: begin
                  if (out_free) begin
                     rsp_load = 1'b1;
                     ld_id    = client_ff;
                     state_in = ST_IDLE;
                     if (!in_range) begin
                        if (head) begin
                           acc_in = 1'b0;
                        end
                     end else begin
                        acc_in = acc_new;
                        if (store) begin
                           tx_we               = 1'b1;
                           fill_we             = 1'b1;
                           nonempty_in[cl_idx] = 1'b1;
                        end
                        ld_ok = store || (head && acc_new && (mlen_ff == 8'd0));
                     end
                  end
               end

               MODE_TX_START: begin
                  if (busy_ff) begin
                     if (out_free) begin
                        rsp_load = 1'b1;
                        state_in = ST_IDLE;
                     end
                  end else begin
                     scan_in  = '0;
                     state_in = ST_SCAN;
                  end
               end

               MODE_TX_DONE: begin
                  busy_in  = 1'b0;
                  state_in = ST_IDLE;
               end

               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         ST_RING: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rp_we    = 1'b1;
               ld_ok    = 1'b1;
               ld_id    = client_ff;
               ld_byte  = ring_rd;
               ld_empty = (rp_next == wp_ff);
               state_in = ST_IDLE;
            end
         end

         ST_SCAN: begin
            // lowest-numbered client with staged bytes wins
            if (nonempty_ff[scan_ff]) begin
               state_in = ST_FILL;
            end else if (scan_ff == CLIENT_LAST) begin
               if (out_free) begin
                  rsp_load = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end

         ST_FILL: begin
            n_in     = fill_rd;
            k_in     = '0;
            state_in = ST_TXRD;
         end

         ST_TXRD: begin
            state_in = ST_TXOUT;
         end

         ST_TXOUT: begin
            if (out_free) begin
               rsp_load = 1'b1;
               ld_ok    = 1'b1;
               ld_id    = 4'(scan_ff);
               ld_byte  = tx_rd;
               ld_line  = 1'b1;
               ld_last  = tx_last;
               if (tx_last) begin
                  fill_we              = 1'b1;
                  fill_waddr           = scan_ff;
                  fill_wdata           = '0;
                  nonempty_in[scan_ff] = 1'b0;
                  busy_in              = 1'b1;
                  state_in             = ST_IDLE;
               end else begin
                  k_in     = k_ff + 1'b1;
                  state_in = ST_TXRD;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wp_ff        <= '0;
         busy_ff      <= 1'b0;
         acc_ff       <= 1'b0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wp_ff        <= wp_in;
         busy_ff      <= busy_in;
         acc_ff       <= acc_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rp_ff   <= rp_in;
      scan_ff <= scan_in;
      k_ff    <= k_in;
      n_ff    <= n_in;
      if (accept) begin
         mode_ff   <= req_mode;
         client_ff <= req_client;
         data_ff   <= req_data_byte;
         mlen_ff   <= req_msg_length;
         pos_ff    <= req_byte_position;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= ld_ok;
         rsp_id_ff    <= ld_id;
         rsp_byte_ff  <= ld_byte;
         rsp_empty_ff <= ld_empty;
         rsp_line_ff  <= ld_line;
         rsp_last_ff  <= ld_last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ok         = rsp_ok_ff;
   assign rsp_client_id  = rsp_id_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_ring_empty = rsp_empty_ff;
   assign rsp_line_valid = rsp_line_ff;
   assign rsp_last       = rsp_last_ff;

   // receive ring, shared by all clients
   mcsfh_ram #(
      .WIDTH (8),
      .DEPTH (RX_RING_DEPTH),
      .AW    (RAW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_we),
      .wr_addr (wp_ff),
      .wr_data (data_ff),
      .rd_addr (ring_raddr),
      .rd_data (ring_rd)
   );

   // transmit staging store, TX_CAPACITY bytes per client
   mcsfh_ram #(
      .WIDTH (8),
      .DEPTH (TXD),
      .AW    (TAW)
   ) u_tx_store (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_waddr),
      .wr_data (data_ff),
      .rd_addr (tx_raddr),
      .rd_data (tx_rd)
   );

   // per-client read pointers
   mcsfh_vtab #(
      .WIDTH (RAW),
      .DEPTH (CLIENTS),
      .AW    (CLW)
   ) u_rp_tab (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (rp_we),
      .wr_addr (cl_idx),
      .wr_data (rp_wdata),
      .rd_addr (rp_raddr),
      .rd_data (rp_rd)
   );

   // per-client transmit fill counts
   mcsfh_vtab #(
      .WIDTH (FW),
      .DEPTH (CLIENTS),
      .AW    (CLW)
   ) u_fill_tab (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (fill_we),
      .wr_addr (fill_waddr),
      .wr_data (fill_wdata),
      .rd_addr (fill_raddr),
      .rd_data (fill_rd)
   );

`ifndef NO_ASSERTIONS
   // a send only runs on a client that really has staged bytes
   a_send_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL || state_ff == ST_TXRD || state_ff == ST_TXOUT)
      |-> nonempty_ff[scan_ff])
      else $error("send in progress on an empty client buffer");

   // final line beat of a run leaves the transmitter busy
   a_busy_after_run: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && ld_line && ld_last) |=> busy_ff)
      else $error("transmitter not busy after a sent run");

   a_wp_range: assert property (@(posedge clock) disable iff (reset)
      wp_ff <= RING_LAST)
      else $error("ring write pointer out of range");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CLIENTS_CNT)
      else $error("client count beyond the client limit");
`endif

endmodule

`default_nettype wire

/* hw/rtl/mcsfh_ram.sv */
// Simple dual-port synchronous RAM, one write and one registered read port.
`default_nettype none

module mcsfh_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/mcsfh_vtab.sv */
// Small per-client table RAM with valid bits; unwritten entries read as zero.
`default_nettype none

module mcsfh_vtab #(
   parameter int WIDTH = 6,
   parameter int DEPTH = 16,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [DEPTH-1:0] valid_ff;
   logic [WIDTH-1:0] rd_data_ff;

   // valid bits clear at reset, so the table reads as all zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[wr_addr] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= valid_ff[rd_addr] ? store_ff[rd_addr] : '0;
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire
